>>> rtl/core/positional_list_engine_unit_defines.svh
// assertion macros used by the checker file
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// clocked check, muted while reset is held
`define PLE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define PLE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ple_pkg.sv
// shared constants, codes and types of the positional list engine
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int REQ_W    = 3;
    localparam int ST_W     = 3;
    // value and position fill whole bytes already
    localparam int TDATA_W  = VAL_W + POS_W;

    // command queue depth, a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_END   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_AFTER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_END   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_AT    = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd6;
    localparam logic [REQ_W-1:0] REQ_DUMP      = 3'd7;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd4;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_SEARCH,
        OP_DUMP
    } op_kind_t;

    typedef enum logic [1:0] {
        WH_FRONT,
        WH_END,
        WH_AT
    } anchor_t;

    typedef struct packed {
        op_kind_t           op;
        anchor_t            anchor;
        logic [VAL_W-1:0]   value;
        logic [POS_W-1:0]   position;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [VAL_W-1:0]   value;
        logic [POS_W-1:0]   position;
        logic               last;
    } result_t;

endpackage

>>> rtl/core/ple_front.sv
// front end: takes request items and decodes them into list commands
module ple_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ple_pkg::REQ_W-1:0]   in_req,
    input  logic [ple_pkg::VAL_W-1:0]   in_value,
    input  logic [ple_pkg::POS_W-1:0]   in_pos,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output ple_pkg::cmd_t               cmd
);

    logic           valid_reg;
    logic           valid_next;
    ple_pkg::cmd_t  cmd_reg;
    ple_pkg::cmd_t  cmd_next;
    logic           load;

    assign in_ready  = !valid_reg || cmd_ready;
    assign load      = in_valid && in_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.value    = in_value;
        cmd_next.position = in_pos;
        cmd_next.op       = ple_pkg::OP_INSERT;
        cmd_next.anchor   = ple_pkg::WH_FRONT;
        unique case (in_req)
            ple_pkg::REQ_INS_FRONT:
            begin
                cmd_next.op     = ple_pkg::OP_INSERT;
                cmd_next.anchor = ple_pkg::WH_FRONT;
            end
            ple_pkg::REQ_INS_END:
            begin
                cmd_next.op     = ple_pkg::OP_INSERT;
                cmd_next.anchor = ple_pkg::WH_END;
            end
            ple_pkg::REQ_INS_AFTER:
            begin
                cmd_next.op     = ple_pkg::OP_INSERT;
                cmd_next.anchor = ple_pkg::WH_AT;
            end
            ple_pkg::REQ_DEL_FRONT:
            begin
                cmd_next.op     = ple_pkg::OP_DELETE;
                cmd_next.anchor = ple_pkg::WH_FRONT;
            end
            ple_pkg::REQ_DEL_END:
            begin
                cmd_next.op     = ple_pkg::OP_DELETE;
                cmd_next.anchor = ple_pkg::WH_END;
            end
            ple_pkg::REQ_DEL_AT:
            begin
                cmd_next.op     = ple_pkg::OP_DELETE;
                cmd_next.anchor = ple_pkg::WH_AT;
            end
            ple_pkg::REQ_SEARCH:
            begin
                cmd_next.op     = ple_pkg::OP_SEARCH;
                cmd_next.anchor = ple_pkg::WH_FRONT;
            end
            ple_pkg::REQ_DUMP:
            begin
                cmd_next.op     = ple_pkg::OP_DUMP;
                cmd_next.anchor = ple_pkg::WH_FRONT;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (cmd_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cmd_reg <= cmd_next;
    end

endmodule

>>> rtl/core/ple_cmd_queue.sv
// short command queue between the front and back ends
module ple_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ple_pkg::cmd_t   in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output ple_pkg::cmd_t   out_cmd
);

    ple_pkg::cmd_t                  slot_reg [ple_pkg::QUEUE_DEPTH];
    logic [ple_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ple_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [ple_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ple_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [ple_pkg::QCNT_W-1:0]     fill_reg;
    logic [ple_pkg::QCNT_W-1:0]     fill_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = fill_reg != ple_pkg::QCNT_W'(ple_pkg::QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + ple_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + ple_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + ple_pkg::QCNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - ple_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

>>> rtl/core/ple_back.sv
// back end: holds the list, runs commands and registers each result item
module ple_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ple_pkg::cmd_t       cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output ple_pkg::result_t    out_result
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    localparam int CAP   = ple_pkg::CAPACITY;
    localparam int CNT_W = ple_pkg::CNT_W;
    localparam int IDX_W = ple_pkg::IDX_W;
    localparam int POS_W = ple_pkg::POS_W;
    localparam int VAL_W = ple_pkg::VAL_W;

    logic [VAL_W-1:0]   entry_reg  [CAP];
    logic [VAL_W-1:0]   entry_next [CAP];

    logic               state_reg;
    logic               state_next;
    logic               scan_dump_reg;
    logic               scan_dump_next;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   scan_idx_next;
    logic [VAL_W-1:0]   key_reg;
    logic [VAL_W-1:0]   key_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ple_pkg::result_t   out_reg;
    ple_pkg::result_t   out_next;

    logic               out_free;
    logic               is_full;
    logic               is_empty;
    logic               pos_bad;
    logic               ok;
    logic               last_entry;
    logic               emit;
    ple_pkg::result_t   res;
    logic               ins_en;
    logic               del_en;
    logic [IDX_W-1:0]   op_idx;
    logic [VAL_W-1:0]   scan_data;

    assign out_free   = !out_valid_reg || out_ready;
    assign cmd_ready  = (state_reg == S_IDLE) && out_free;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    assign is_full    = count_reg == CNT_W'(CAP);
    assign is_empty   = count_reg == '0;
    assign pos_bad    = (cmd.position == '0) || (cmd.position > POS_W'(count_reg));
    assign scan_data  = entry_reg[scan_idx_reg];
    assign last_entry = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next     = state_reg;
        scan_dump_next = scan_dump_reg;
        scan_idx_next  = scan_idx_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        ins_en         = 1'b0;
        del_en         = 1'b0;
        op_idx         = '0;
        ok             = 1'b0;
        emit           = 1'b0;
        res            = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    unique case (cmd.op)
                        ple_pkg::OP_INSERT:
                        begin
                            emit = 1'b1;
                            if (is_full)
                                res = '{ple_pkg::ST_FULL, cmd.value, '0, 1'b1};
                            else
                            begin
                                unique case (cmd.anchor)
                                    ple_pkg::WH_FRONT:
                                    begin
                                        ok     = 1'b1;
                                        op_idx = '0;
                                    end
                                    ple_pkg::WH_END:
                                    begin
                                        ok     = 1'b1;
                                        op_idx = count_reg[IDX_W-1:0];
                                    end
                                    ple_pkg::WH_AT:
                                    begin
                                        // an empty list only takes position one
                                        if (is_empty)
                                        begin
                                            ok     = cmd.position == POS_W'(1);
                                            op_idx = '0;
                                        end
                                        else
                                        begin
                                            ok     = !pos_bad;
                                            op_idx = cmd.position[IDX_W-1:0];
                                        end
                                    end
                                    default:
                                    begin
                                        ok     = 1'b0;
                                        op_idx = '0;
                                    end
                                endcase
                                if (ok)
                                begin
                                    ins_en     = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                    res        = '{ple_pkg::ST_OK, cmd.value,
                                                   POS_W'(op_idx) + POS_W'(1), 1'b1};
                                end
                                else
                                    res = '{ple_pkg::ST_RANGE, cmd.value, '0, 1'b1};
                            end
                        end
                        ple_pkg::OP_DELETE:
                        begin
                            emit = 1'b1;
                            if (is_empty)
                                res = '{ple_pkg::ST_EMPTY, '0, '0, 1'b1};
                            else
                            begin
                                unique case (cmd.anchor)
                                    ple_pkg::WH_FRONT:
                                    begin
                                        ok     = 1'b1;
                                        op_idx = '0;
                                    end
                                    ple_pkg::WH_END:
                                    begin
                                        ok     = 1'b1;
                                        op_idx = IDX_W'(count_reg - CNT_W'(1));
                                    end
                                    ple_pkg::WH_AT:
                                    begin
                                        ok     = !pos_bad;
                                        op_idx = IDX_W'(cmd.position - POS_W'(1));
                                    end
                                    default:
                                    begin
                                        ok     = 1'b0;
                                        op_idx = '0;
                                    end
                                endcase
                                if (ok)
                                begin
                                    del_en     = 1'b1;
                                    count_next = count_reg - CNT_W'(1);
                                    res        = '{ple_pkg::ST_OK, entry_reg[op_idx],
                                                   POS_W'(op_idx) + POS_W'(1), 1'b1};
                                end
                                else
                                    res = '{ple_pkg::ST_RANGE, '0, '0, 1'b1};
                            end
                        end
                        ple_pkg::OP_SEARCH:
                        begin
                            if (is_empty)
                            begin
                                emit = 1'b1;
                                res  = '{ple_pkg::ST_EMPTY, cmd.value, '0, 1'b1};
                            end
                            else
                            begin
                                state_next     = S_SCAN;
                                scan_dump_next = 1'b0;
                                scan_idx_next  = '0;
                                key_next       = cmd.value;
                            end
                        end
                        ple_pkg::OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                emit = 1'b1;
                                res  = '{ple_pkg::ST_EMPTY, '0, '0, 1'b1};
                            end
                            else
                            begin
                                state_next     = S_SCAN;
                                scan_dump_next = 1'b1;
                                scan_idx_next  = '0;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one entry per cycle, held while the output register is full
                if (out_free)
                begin
                    if (scan_dump_reg)
                    begin
                        emit = 1'b1;
                        res  = '{ple_pkg::ST_OK, scan_data,
                                 POS_W'(scan_idx_reg) + POS_W'(1), last_entry};
                        if (last_entry)
                            state_next = S_IDLE;
                        else
                            scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                    else if (scan_data == key_reg)
                    begin
                        emit       = 1'b1;
                        res        = '{ple_pkg::ST_OK, key_reg,
                                       POS_W'(scan_idx_reg) + POS_W'(1), 1'b1};
                        state_next = S_IDLE;
                    end
                    else if (last_entry)
                    begin
                        emit       = 1'b1;
                        res        = '{ple_pkg::ST_MISSING, key_reg, '0, 1'b1};
                        state_next = S_IDLE;
                    end
                    else
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        out_next = emit ? res : out_reg;
    end

    // cells at or above the slot load from a neighbor, or the new value, when a slot opens or closes
    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        logic [VAL_W-1:0] lower;
        logic [VAL_W-1:0] upper;

        if (g == 0)
        begin : g_first
            assign lower = entry_reg[g];
        end
        else
        begin : g_mid_lo
            assign lower = entry_reg[g-1];
        end

        if (g == CAP - 1)
        begin : g_last
            assign upper = entry_reg[g];
        end
        else
        begin : g_mid_hi
            assign upper = entry_reg[g+1];
        end

        always_comb
        begin
            entry_next[g] = entry_reg[g];
            if (ins_en)
            begin
                if (IDX_W'(g) == op_idx)
                    entry_next[g] = cmd.value;
                else if (IDX_W'(g) > op_idx)
                    entry_next[g] = lower;
            end
            else if (del_en && (IDX_W'(g) >= op_idx))
                entry_next[g] = upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_dump_reg <= 1'b0;
            scan_idx_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_dump_reg <= scan_dump_next;
            scan_idx_reg  <= scan_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        out_reg   <= out_next;
        entry_reg <= entry_next;
    end

endmodule

>>> rtl/core/positional_list_engine_unit.sv
// top level of the positional list engine
// Ordered list of up to 16 signed 32-bit values, numbered from position 1.
// A request item passes a decode register and a two-deep command queue, so
// the input takes items while the back end is busy, until both are full.
// In the back end the list is a row of registers: an insert or a delete shifts
// all registers from the slot up by one place at once. A search compares one
// entry per cycle from the front; a dump gives one result item per cycle; both
// read the list through a single read port and wait while the output register
// is full. Insert and delete requests are taken one per cycle while results
// are taken. Results leave through a registered output stage.
module positional_list_engine_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // item_value [31:0], position [39:32]
    input  logic [ple_pkg::TDATA_W-1:0]     s_axis_tdata,
    // req_type [2:0]
    input  logic [ple_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // result_value [31:0], result_position [39:32]
    output logic [ple_pkg::TDATA_W-1:0]     m_axis_tdata,
    // status [2:0]
    output logic [ple_pkg::ST_W-1:0]        m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic               front_valid;
    logic               front_ready;
    ple_pkg::cmd_t      front_cmd;
    logic               queue_valid;
    logic               queue_ready;
    ple_pkg::cmd_t      queue_cmd;
    ple_pkg::result_t   result;

    ple_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_axis_tuser),
        .in_value  (s_axis_tdata[ple_pkg::VAL_W-1:0]),
        .in_pos    (s_axis_tdata[ple_pkg::VAL_W +: ple_pkg::POS_W]),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    ple_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    ple_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_valid),
        .cmd_ready  (queue_ready),
        .cmd        (queue_cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {result.position, result.value};
    assign m_axis_tuser = result.status;
    assign m_axis_tlast = result.last;

endmodule

>>> rtl/core/ple_checker.sv
// port-level checks on the positional list engine and their bind
`include "positional_list_engine_unit_defines.svh"

module ple_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ple_pkg::TDATA_W-1:0]  m_axis_tdata,
    input logic [ple_pkg::ST_W-1:0]     m_axis_tuser,
    input logic                         m_axis_tlast
);

    // no result item may be offered while reset is held
    `PLE_ASSERT_RST(a_no_out_in_reset, clk, !rst_n |-> !m_axis_tvalid, "result valid during reset")

    // a stalled result item holds
    `PLE_ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // a successful item always names a real position
    `PLE_ASSERT_CLK(a_ok_has_pos, clk, rst_n, m_axis_tvalid && (m_axis_tuser == ple_pkg::ST_OK) |-> (m_axis_tdata[39:32] != 8'd0), "ok result without position")

    // a failed request gives one closing item with no position
    `PLE_ASSERT_CLK(a_fail_closes, clk, rst_n, m_axis_tvalid && (m_axis_tuser != ple_pkg::ST_OK) |-> m_axis_tlast && (m_axis_tdata[39:32] == 8'd0), "failed result not final or has position")

endmodule

bind positional_list_engine_unit ple_checker u_checker (.*);

>>> tb/testbench.sv
// self-checking testbench of the positional list engine: random and directed requests
`timescale 1ns / 100ps

// keeps its own copy of the list and the results it still owes
class list_tracker;
    logic [ple_pkg::VAL_W-1:0] entries[$];
    ple_pkg::result_t          owed[$];
    int                        failures;

    function new();
        failures = 0;
    endfunction

    function int pending();
        return owed.size();
    endfunction

    function void owe(logic [ple_pkg::ST_W-1:0] st, logic [ple_pkg::VAL_W-1:0] val,
                      int pos, logic fin);
        ple_pkg::result_t res;
        res.status   = st;
        res.value    = val;
        res.position = pos[ple_pkg::POS_W-1:0];
        res.last     = fin;
        owed.push_back(res);
    endfunction

    // apply one accepted request to the list and queue the result items it causes
    function void note_request(logic [ple_pkg::REQ_W-1:0] req,
                               logic [ple_pkg::VAL_W-1:0] val,
                               logic [ple_pkg::POS_W-1:0] pos);
        int                        n;
        logic [ple_pkg::VAL_W-1:0] v;
        n = entries.size();
        case (req)
            ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_END, ple_pkg::REQ_INS_AFTER:
            begin
                // a full list is reported before the position is looked at
                if (n >= ple_pkg::CAPACITY)
                    owe(ple_pkg::ST_FULL, val, 0, 1'b1);
                else if (req == ple_pkg::REQ_INS_FRONT)
                begin
                    entries.push_front(val);
                    owe(ple_pkg::ST_OK, val, 1, 1'b1);
                end
                else if (req == ple_pkg::REQ_INS_END)
                begin
                    entries.push_back(val);
                    owe(ple_pkg::ST_OK, val, n + 1, 1'b1);
                end
                else if (n == 0)
                begin
                    if (pos == 1)
                    begin
                        entries.push_front(val);
                        owe(ple_pkg::ST_OK, val, 1, 1'b1);
                    end
                    else
                        owe(ple_pkg::ST_RANGE, val, 0, 1'b1);
                end
                else if (pos == 0 || pos > n)
                    owe(ple_pkg::ST_RANGE, val, 0, 1'b1);
                else
                begin
                    entries.insert(pos, val);
                    owe(ple_pkg::ST_OK, val, pos + 1, 1'b1);
                end
            end
            ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_END, ple_pkg::REQ_DEL_AT:
            begin
                if (n == 0)
                    owe(ple_pkg::ST_EMPTY, '0, 0, 1'b1);
                else if (req == ple_pkg::REQ_DEL_FRONT)
                begin
                    v = entries.pop_front();
                    owe(ple_pkg::ST_OK, v, 1, 1'b1);
                end
                else if (req == ple_pkg::REQ_DEL_END)
                begin
                    v = entries.pop_back();
                    owe(ple_pkg::ST_OK, v, n, 1'b1);
                end
                else if (pos == 0 || pos > n)
                    owe(ple_pkg::ST_RANGE, '0, 0, 1'b1);
                else
                begin
                    v = entries[pos - 1];
                    entries.delete(pos - 1);
                    owe(ple_pkg::ST_OK, v, pos, 1'b1);
                end
            end
            ple_pkg::REQ_SEARCH:
            begin
                if (n == 0)
                    owe(ple_pkg::ST_EMPTY, val, 0, 1'b1);
                else
                begin
                    v = '1;
                    for (int k = 0; k < n; k++)
                    begin
                        if (entries[k] == val && v == '1)
                        begin
                            owe(ple_pkg::ST_OK, val, k + 1, 1'b1);
                            v = '0;
                        end
                    end
                    if (v == '1)
                        owe(ple_pkg::ST_MISSING, val, 0, 1'b1);
                end
            end
            default:
            begin
                if (n == 0)
                    owe(ple_pkg::ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int k = 0; k < n; k++)
                        owe(ple_pkg::ST_OK, entries[k], k + 1, k == n - 1);
            end
        endcase
    endfunction

    function void check_result(logic [ple_pkg::ST_W-1:0] st, logic [ple_pkg::VAL_W-1:0] val,
                               logic [ple_pkg::POS_W-1:0] pos, logic fin);
        ple_pkg::result_t want;
        if (owed.size() == 0)
        begin
            $error("result item with none expected: status %0d value %0d position %0d",
                   st, $signed(val), pos);
            failures++;
            return;
        end
        want = owed.pop_front();
        if (want.status !== st)
        begin
            $error("status: expected %0d, got %0d", want.status, st);
            failures++;
        end
        if (want.value !== val)
        begin
            $error("result_value: expected %0d, got %0d", $signed(want.value), $signed(val));
            failures++;
        end
        if (want.position !== pos)
        begin
            $error("result_position: expected %0d, got %0d", want.position, pos);
            failures++;
        end
        if (want.last !== fin)
        begin
            $error("last: expected %0d, got %0d", want.last, fin);
            failures++;
        end
    endfunction
endclass

module testbench;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 236;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_ANY
    } mix_t;

    localparam logic [ple_pkg::REQ_W-1:0] INSERTS[3] =
        '{ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_END, ple_pkg::REQ_INS_AFTER};
    localparam logic [ple_pkg::REQ_W-1:0] DELETES[3] =
        '{ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_END, ple_pkg::REQ_DEL_AT};
    localparam logic [ple_pkg::VAL_W-1:0] EDGE_VALUES[4] =
        '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [ple_pkg::TDATA_W-1:0]    s_axis_tdata;
    logic [ple_pkg::REQ_W-1:0]      s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [ple_pkg::TDATA_W-1:0]    m_axis_tdata;
    logic [ple_pkg::ST_W-1:0]       m_axis_tuser;
    logic                           m_axis_tlast;

    list_tracker tracker = new();
    logic        no_idle;
    int          quiet_cycles;

    positional_list_engine_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // valid stays high between back-to-back items, it drops only for a gap
    task automatic send_request(input logic [ple_pkg::REQ_W-1:0] req,
                                input logic [ple_pkg::VAL_W-1:0] val,
                                input logic [ple_pkg::POS_W-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, val};
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        tracker.note_request(req, val, pos);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    // result side
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            tracker.check_result(m_axis_tuser, m_axis_tdata[ple_pkg::VAL_W-1:0],
                                 m_axis_tdata[ple_pkg::TDATA_W-1:ple_pkg::VAL_W],
                                 m_axis_tlast);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        mix_t                       mode;
        int                         episode_left;
        int                         n;
        int                         r;
        logic [ple_pkg::REQ_W-1:0]  req;
        logic [ple_pkg::VAL_W-1:0]  val;
        logic [ple_pkg::POS_W-1:0]  pos;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ple_pkg::REQ_INS_FRONT;
        no_idle       = 1'b0;
        episode_left  = 0;
        mode          = MIX_ANY;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // deletes, searches, dumps and positional inserts on an empty list
        send_request(ple_pkg::REQ_DUMP,      32'h0,         8'd0);
        send_request(ple_pkg::REQ_DEL_FRONT, 32'h0,         8'd0);
        send_request(ple_pkg::REQ_DEL_END,   32'h0,         8'd0);
        send_request(ple_pkg::REQ_DEL_AT,    32'h0,         8'd255);
        send_request(ple_pkg::REQ_SEARCH,    32'h1234_5678, 8'd1);
        send_request(ple_pkg::REQ_INS_AFTER, 32'h0000_0011, 8'd0);
        send_request(ple_pkg::REQ_INS_AFTER, 32'h0000_0022, 8'd2);
        send_request(ple_pkg::REQ_INS_AFTER, 32'h0000_0000, 8'd1);
        // extremes and positions around the ends
        send_request(ple_pkg::REQ_INS_FRONT, 32'h8000_0000, 8'd0);
        send_request(ple_pkg::REQ_INS_END,   32'h7fff_ffff, 8'd255);
        send_request(ple_pkg::REQ_INS_AFTER, 32'hffff_ffff, 8'd3);
        send_request(ple_pkg::REQ_INS_AFTER, 32'h0000_0033, 8'd5);
        send_request(ple_pkg::REQ_INS_AFTER, 32'h0000_0044, 8'd0);
        send_request(ple_pkg::REQ_INS_AFTER, 32'h0000_0005, 8'd1);
        send_request(ple_pkg::REQ_SEARCH,    32'h7fff_ffff, 8'd0);
        send_request(ple_pkg::REQ_SEARCH,    32'h1234_5678, 8'd0);
        send_request(ple_pkg::REQ_DEL_AT,    32'h0,         8'd0);
        send_request(ple_pkg::REQ_DEL_AT,    32'h0,         8'd6);
        send_request(ple_pkg::REQ_DEL_AT,    32'h0,         8'd2);
        send_request(ple_pkg::REQ_DUMP,      32'h0,         8'd0);
        send_request(ple_pkg::REQ_DEL_FRONT, 32'h0,         8'd0);
        send_request(ple_pkg::REQ_DEL_END,   32'h0,         8'd0);
        send_request(ple_pkg::REQ_DUMP,      32'h0,         8'd0);
        drain_results();

        // episodes of filling, draining and free mixing with random content
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 60 && i < 100);
            if (episode_left == 0)
            begin
                mode         = mix_t'($urandom_range(0, 2));
                episode_left = $urandom_range(8, 30);
            end
            episode_left--;
            n = tracker.entries.size();
            r = $urandom_range(0, 7);
            case (mode)
                MIX_FILL:
                    req = (r < 6) ? INSERTS[r % 3]
                                  : (r == 6 ? ple_pkg::REQ_SEARCH : ple_pkg::REQ_DUMP);
                MIX_DRAIN:
                    req = (r < 6) ? DELETES[r % 3]
                                  : (r == 6 ? ple_pkg::REQ_SEARCH : ple_pkg::REQ_DUMP);
                default:
                    req = ple_pkg::REQ_W'($urandom_range(0, 7));
            endcase
            r = $urandom_range(0, 7);
            if (req == ple_pkg::REQ_SEARCH && n > 0 && r < 4)
                val = tracker.entries[$urandom_range(0, n - 1)];
            else if (r == 0)
                val = EDGE_VALUES[$urandom_range(0, 3)];
            else if (r < 3)
                val = $urandom_range(0, 3);
            else
                val = $urandom;
            if ($urandom_range(0, 3) == 0)
                pos = ple_pkg::POS_W'($urandom_range(0, 255));
            else
                pos = ple_pkg::POS_W'($urandom_range(0, n + 1));
            send_request(req, val, pos);
            if (i == RANDOM_ITEMS / 2)
                drain_results();
        end
        no_idle = 1'b0;

        drain_results();
        repeat (40) @(posedge clk);
        if (tracker.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
